### rtl/core/mfsp_pkg.sv
// package with types and constants for the midi file stream parser
`default_nettype none
package mfsp_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tick_time;
    logic [7:0]  status_byte;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [1:0]  data_count;
    logic [27:0] meta_length;
    logic [15:0] track_number;
    logic [15:0] ticks_per_quarter;
    logic [15:0] track_total;
    logic [2:0]  error_code;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_HTAG, PH_HLEN, PH_HFMT, PH_HNTRK, PH_HDIV, PH_TTAG, PH_TLEN, PH_DELTA,
    PH_STATUS, PH_CD1, PH_CD2, PH_MTYPE, PH_MLEN, PH_MDATA, PH_MSKIP, PH_XLEN,
    PH_XDATA, PH_DONE
  } phase_t;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_TRACK  = 3'd1;
  localparam logic [2:0] KIND_CHAN   = 3'd2;
  localparam logic [2:0] KIND_MHDR   = 3'd3;
  localparam logic [2:0] KIND_MDATA  = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  localparam logic [2:0] ERR_HTAG    = 3'd0;
  localparam logic [2:0] ERR_HLEN    = 3'd1;
  localparam logic [2:0] ERR_FMT     = 3'd2;
  localparam logic [2:0] ERR_TTAG    = 3'd3;
  localparam logic [2:0] ERR_SYSEX   = 3'd4;
  localparam logic [2:0] ERR_SYSTEM  = 3'd5;
  localparam logic [2:0] ERR_RUNNING = 3'd6;
  localparam logic [2:0] ERR_OVERRUN = 3'd7;

  localparam logic [31:0] TAG_HEADER = 32'h4D54_6864;
  localparam logic [31:0] TAG_TRACK  = 32'h4D54_726B;
  localparam logic [7:0]  META_EOT   = 8'h2F;
  localparam logic [7:0]  SYSEX_END  = 8'hF7;
  localparam logic [7:0]  SYSEX_BEG  = 8'hF0;
  localparam logic [7:0]  META_STAT  = 8'hFF;

endpackage
`default_nettype wire

### rtl/core/midi_file_stream_parser_core.sv
// top level of the midi file stream parser
// Takes one byte of a Standard MIDI File (format 0 or 1) per transaction and
// gives at most one result per byte: header, track begin, channel event, meta
// header, meta data byte or error. A byte can be accepted every cycle as long as
// the result register is free or is being emptied in the same cycle; each byte
// passes one layer of decode logic into that single result register. Errors
// are sticky until a byte marked first_byte restarts the parser.
`default_nettype none
module midi_file_stream_parser_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mfsp_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mfsp_pkg::out_item_t     out_data
);

  mfsp_pkg::phase_t phase, phase_next;
  logic [31:0] field_acc, field_acc_next;
  logic [2:0]  field_idx, field_idx_next;
  logic [31:0] chunk_rem, chunk_rem_next;
  logic [31:0] track_time, track_time_next;
  logic [7:0]  running_status, running_status_next;
  logic [7:0]  held_status, held_status_next;
  logic [7:0]  held_data, held_data_next;
  logic [27:0] payload_rem, payload_rem_next;
  logic [15:0] tracks_left, tracks_left_next;
  logic [15:0] track_counter, track_counter_next;
  logic [15:0] division, division_next;
  logic        error_flag, error_flag_next;

  logic        emit;
  mfsp_pkg::out_item_t res;
  logic        take;

  logic [7:0]  b;
  logic [31:0] fix_acc;
  logic [2:0]  fix_idx;
  logic [27:0] vlq_acc;
  logic        vlq_done;
  logic [27:0] pay_dec;
  logic        body;
  logic        rst_in;
  mfsp_pkg::phase_t ph;
  logic [2:0]  fi;
  logic [31:0] fa;
  logic [15:0] tl;
  logic [15:0] tc;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    rst_in = in_data.first_byte;
    ph = rst_in ? mfsp_pkg::PH_HTAG : phase;
    fa = rst_in ? 32'd0 : field_acc;
    fi = rst_in ? 3'd0 : field_idx;
    tl = rst_in ? 16'd0 : tracks_left;
    tc = rst_in ? 16'd0 : track_counter;
    b = in_data.file_byte;
    fix_acc = {fa[23:0], b};
    fix_idx = fi + 3'd1;
    vlq_acc = {fa[20:0], b[6:0]};
    vlq_done = !b[7] || (fix_idx >= 3'd4);
    pay_dec = payload_rem - 28'd1;

    phase_next          = ph;
    field_acc_next      = fa;
    field_idx_next      = fi;
    chunk_rem_next      = rst_in ? 32'd0 : chunk_rem;
    track_time_next     = rst_in ? 32'd0 : track_time;
    running_status_next = rst_in ? 8'd0 : running_status;
    held_status_next    = rst_in ? 8'd0 : held_status;
    held_data_next      = rst_in ? 8'd0 : held_data;
    payload_rem_next    = rst_in ? 28'd0 : payload_rem;
    tracks_left_next    = tl;
    track_counter_next  = tc;
    division_next       = rst_in ? 16'd0 : division;
    error_flag_next     = rst_in ? 1'b0 : error_flag;
    emit = 1'b0;
    res  = '0;
    body = (ph >= mfsp_pkg::PH_DELTA) && (ph <= mfsp_pkg::PH_XDATA);

    if (!error_flag_next) begin
      case (ph)
        mfsp_pkg::PH_HTAG, mfsp_pkg::PH_HLEN, mfsp_pkg::PH_TTAG,
        mfsp_pkg::PH_TLEN: begin
          field_acc_next = fix_acc;
          field_idx_next = fix_idx;
          if (fix_idx == 3'd4) begin
            field_idx_next = 3'd0;
            field_acc_next = '0;
            case (ph)
              mfsp_pkg::PH_HTAG: begin
                if (fix_acc != mfsp_pkg::TAG_HEADER) begin
                  error_flag_next = 1'b1; emit = 1'b1;
                  res.kind = mfsp_pkg::KIND_ERROR; res.error_code = mfsp_pkg::ERR_HTAG;
                end else phase_next = mfsp_pkg::PH_HLEN;
              end
              mfsp_pkg::PH_HLEN: begin
                if (fix_acc != 32'd6) begin
                  error_flag_next = 1'b1; emit = 1'b1;
                  res.kind = mfsp_pkg::KIND_ERROR; res.error_code = mfsp_pkg::ERR_HLEN;
                end else phase_next = mfsp_pkg::PH_HFMT;
              end
              mfsp_pkg::PH_TTAG: begin
                if (fix_acc != mfsp_pkg::TAG_TRACK) begin
                  error_flag_next = 1'b1; emit = 1'b1;
                  res.kind = mfsp_pkg::KIND_ERROR; res.error_code = mfsp_pkg::ERR_TTAG;
                end else phase_next = mfsp_pkg::PH_TLEN;
              end
              default: begin
                chunk_rem_next = fix_acc;
                track_time_next = '0;
                running_status_next = '0;
                emit = 1'b1;
                res.kind = mfsp_pkg::KIND_TRACK;
                res.track_number = tc;
                phase_next = mfsp_pkg::PH_DELTA;
                if (fix_acc == 32'd0) begin
                  tracks_left_next = tl - 16'd1;
                  track_counter_next = tc + 16'd1;
                  phase_next = (tl != 16'd1) ? mfsp_pkg::PH_TTAG : mfsp_pkg::PH_DONE;
                end
              end
            endcase
          end
        end
        mfsp_pkg::PH_HFMT, mfsp_pkg::PH_HNTRK, mfsp_pkg::PH_HDIV: begin
          field_acc_next = fix_acc;
          field_idx_next = fix_idx;
          if (fix_idx == 3'd2) begin
            field_idx_next = 3'd0;
            field_acc_next = '0;
            case (ph)
              mfsp_pkg::PH_HFMT: begin
                if (fix_acc[15:0] > 16'd1) begin
                  error_flag_next = 1'b1; emit = 1'b1;
                  res.kind = mfsp_pkg::KIND_ERROR; res.error_code = mfsp_pkg::ERR_FMT;
                end else phase_next = mfsp_pkg::PH_HNTRK;
              end
              mfsp_pkg::PH_HNTRK: begin
                tracks_left_next = fix_acc[15:0];
                phase_next = mfsp_pkg::PH_HDIV;
              end
              default: begin
                division_next = fix_acc[15:0];
                emit = 1'b1;
                res.kind = mfsp_pkg::KIND_HEADER;
                res.track_number = tc;
                res.ticks_per_quarter = fix_acc[15:0];
                res.track_total = tl;
                phase_next = (tl != 16'd0) ? mfsp_pkg::PH_TTAG : mfsp_pkg::PH_DONE;
              end
            endcase
          end
        end
        mfsp_pkg::PH_DELTA: begin
          field_acc_next = {4'd0, vlq_acc};
          field_idx_next = fix_idx;
          if (vlq_done) begin
            field_idx_next = 3'd0;
            field_acc_next = '0;
            track_time_next = track_time_next + {4'd0, vlq_acc};
            phase_next = mfsp_pkg::PH_STATUS;
          end
        end
        mfsp_pkg::PH_STATUS: begin
          if (b[7]) begin
            if (b >= 8'hF0) begin
              running_status_next = '0;
              if (b == mfsp_pkg::META_STAT) phase_next = mfsp_pkg::PH_MTYPE;
              else if (b == mfsp_pkg::SYSEX_BEG || b == mfsp_pkg::SYSEX_END)
                phase_next = mfsp_pkg::PH_XLEN;
              else begin
                error_flag_next = 1'b1; emit = 1'b1;
                res.kind = mfsp_pkg::KIND_ERROR; res.error_code = mfsp_pkg::ERR_SYSTEM;
              end
            end else begin
              running_status_next = b;
              held_status_next = b;
              phase_next = mfsp_pkg::PH_CD1;
            end
          end else if (running_status_next == 8'd0) begin
            error_flag_next = 1'b1; emit = 1'b1;
            res.kind = mfsp_pkg::KIND_ERROR; res.error_code = mfsp_pkg::ERR_RUNNING;
          end else begin
            held_status_next = running_status_next;
            if (running_status_next[7:5] == 3'b110) begin
              emit = 1'b1;
              res.kind = mfsp_pkg::KIND_CHAN;
              res.status_byte = running_status_next;
              res.data_first = b;
              res.data_count = 2'd1;
              phase_next = mfsp_pkg::PH_DELTA;
            end else begin
              held_data_next = b;
              phase_next = mfsp_pkg::PH_CD2;
            end
          end
        end
        mfsp_pkg::PH_CD1: begin
          if (held_status[7:5] == 3'b110) begin
            emit = 1'b1;
            res.kind = mfsp_pkg::KIND_CHAN;
            res.status_byte = held_status;
            res.data_first = b;
            res.data_count = 2'd1;
            phase_next = mfsp_pkg::PH_DELTA;
          end else begin
            held_data_next = b;
            phase_next = mfsp_pkg::PH_CD2;
          end
        end
        mfsp_pkg::PH_CD2: begin
          emit = 1'b1;
          res.kind = mfsp_pkg::KIND_CHAN;
          res.status_byte = held_status;
          res.data_first = held_data;
          res.data_second = b;
          res.data_count = 2'd2;
          phase_next = mfsp_pkg::PH_DELTA;
        end
        mfsp_pkg::PH_MTYPE: begin
          held_data_next = b;
          phase_next = mfsp_pkg::PH_MLEN;
        end
        mfsp_pkg::PH_MLEN, mfsp_pkg::PH_XLEN: begin
          field_acc_next = {4'd0, vlq_acc};
          field_idx_next = fix_idx;
          if (vlq_done) begin
            field_idx_next = 3'd0;
            field_acc_next = '0;
            payload_rem_next = vlq_acc;
            if (ph == mfsp_pkg::PH_XLEN) begin
              if (vlq_acc == 28'd0) begin
                error_flag_next = 1'b1; emit = 1'b1;
                res.kind = mfsp_pkg::KIND_ERROR; res.error_code = mfsp_pkg::ERR_SYSEX;
              end else phase_next = mfsp_pkg::PH_XDATA;
            end else if (held_data == mfsp_pkg::META_EOT) begin
              phase_next = (vlq_acc != 28'd0) ? mfsp_pkg::PH_MSKIP : mfsp_pkg::PH_DELTA;
            end else begin
              emit = 1'b1;
              res.kind = mfsp_pkg::KIND_MHDR;
              res.status_byte = mfsp_pkg::META_STAT;
              res.data_first = held_data;
              res.meta_length = vlq_acc;
              phase_next = (vlq_acc != 28'd0) ? mfsp_pkg::PH_MDATA : mfsp_pkg::PH_DELTA;
            end
          end
        end
        mfsp_pkg::PH_MDATA, mfsp_pkg::PH_MSKIP: begin
          if (ph == mfsp_pkg::PH_MDATA) begin
            emit = 1'b1;
            res.kind = mfsp_pkg::KIND_MDATA;
            res.status_byte = mfsp_pkg::META_STAT;
            res.data_first = held_data;
            res.data_second = b;
          end
          payload_rem_next = pay_dec;
          if (pay_dec == 28'd0) phase_next = mfsp_pkg::PH_DELTA;
        end
        mfsp_pkg::PH_XDATA: begin
          payload_rem_next = pay_dec;
          if (pay_dec == 28'd0) begin
            if (b != mfsp_pkg::SYSEX_END) begin
              error_flag_next = 1'b1; emit = 1'b1;
              res.kind = mfsp_pkg::KIND_ERROR; res.error_code = mfsp_pkg::ERR_SYSEX;
            end else phase_next = mfsp_pkg::PH_DELTA;
          end
        end
        default: begin
        end
      endcase

      if (res.kind != mfsp_pkg::KIND_HEADER) res.tick_time = track_time_next;
      res.track_number = tc;

      if (body && !error_flag_next) begin
        chunk_rem_next = chunk_rem - 32'd1;
        if (chunk_rem_next == 32'd0) begin
          if (phase_next == mfsp_pkg::PH_DELTA && field_idx_next == 3'd0) begin
            tracks_left_next = tl - 16'd1;
            track_counter_next = tc + 16'd1;
            phase_next = (tl != 16'd1) ? mfsp_pkg::PH_TTAG : mfsp_pkg::PH_DONE;
          end else begin
            error_flag_next = 1'b1;
            emit = 1'b1;
            res = '0;
            res.kind = mfsp_pkg::KIND_ERROR;
            res.error_code = mfsp_pkg::ERR_OVERRUN;
            res.tick_time = track_time_next;
            res.track_number = tc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mfsp_pkg::PH_HTAG;
      field_acc      <= '0;
      field_idx      <= '0;
      chunk_rem      <= '0;
      track_time     <= '0;
      running_status <= '0;
      held_status    <= '0;
      held_data      <= '0;
      payload_rem    <= '0;
      tracks_left    <= '0;
      track_counter  <= '0;
      division       <= '0;
      error_flag     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        phase          <= phase_next;
        field_acc      <= field_acc_next;
        field_idx      <= field_idx_next;
        chunk_rem      <= chunk_rem_next;
        track_time     <= track_time_next;
        running_status <= running_status_next;
        held_status    <= held_status_next;
        held_data      <= held_data_next;
        payload_rem    <= payload_rem_next;
        tracks_left    <= tracks_left_next;
        track_counter  <= track_counter_next;
        division       <= division_next;
        error_flag     <= error_flag_next;
        out_valid      <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire
